// ===== hdl/uabs_pkg.sv =====
// ----------------------------------------------------------------------------
// uabs_pkg
// Shared widths, codes and handshake structs of the binary uABS coder.
// ----------------------------------------------------------------------------
package uabs_pkg;

  localparam int STACK_DEPTH = 4096;
  localparam int AW          = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

  localparam int STATE_W  = 24;
  localparam int PROB_W   = 17;
  localparam int BASE_W   = 9;
  localparam int DIGIT_W  = 8;
  localparam int CMD_W    = 2;
  localparam int CFGI_W   = 2;
  localparam int STORED_W = 13;
  localparam int LIMIT_W  = PROB_W + BASE_W;

  // Serial divider: dividend, remainder and iteration counter widths.
  localparam int DIV_W  = 42;
  localparam int REM_W  = PROB_W + 1;
  localparam int DCNT_W = $clog2(DIV_W + 1);

  localparam logic [CMD_W-1:0] CMD_ENCODE  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DECODE  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RESTART = 2'd2;

  localparam logic [CFGI_W-1:0] REG_PROB_SCALE    = 2'd0;
  localparam logic [CFGI_W-1:0] REG_DIGIT_BASE    = 2'd1;
  localparam logic [CFGI_W-1:0] REG_INITIAL_STATE = 2'd2;

  localparam logic [PROB_W-1:0]  SCALE_RESET = 17'd4096;
  localparam logic [BASE_W-1:0]  BASE_RESET  = 9'd2;
  localparam logic [STATE_W-1:0] INIT_RESET  = 24'd4096;
  localparam logic [PROB_W-1:0]  SCALE_MIN   = 17'd2;
  localparam logic [PROB_W-1:0]  SCALE_MAX   = 17'd65536;
  localparam logic [BASE_W-1:0]  BASE_MIN    = 9'd2;
  localparam logic [BASE_W-1:0]  BASE_MAX    = 9'd256;

  typedef struct packed {
    logic               start;
    logic               short_op;   // dividend fits in STATE_W bits
    logic [DIV_W-1:0]   dividend;
    logic [PROB_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic               busy;
    logic               done;
    logic [DIV_W-1:0]   quotient;
    logic [PROB_W-1:0]  remainder;
  } div_rsp_t;

endpackage

// ===== hdl/uabs_in_if.sv =====
// ----------------------------------------------------------------------------
// uabs_in_if
// Input item channel: command, symbol and probability of a one.
// ----------------------------------------------------------------------------
interface uabs_in_if import uabs_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic              symbol;
  logic [PROB_W-1:0] prob_one;

  modport source (output valid, command, symbol, prob_one, input ready);
  modport sink   (input valid, command, symbol, prob_one, output ready);
endinterface

// ===== hdl/uabs_out_if.sv =====
// ----------------------------------------------------------------------------
// uabs_out_if
// Result item channel: decoded bit, stack fill, state and flags.
// ----------------------------------------------------------------------------
interface uabs_out_if import uabs_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                decoded_bit;
  logic [STORED_W-1:0] digits_stored;
  logic [STATE_W-1:0]  coder_value;
  logic                prob_error;
  logic                stack_overflow;

  modport source (output valid, decoded_bit, digits_stored, coder_value, prob_error,
                  stack_overflow, input ready);
  modport sink   (input valid, decoded_bit, digits_stored, coder_value, prob_error,
                  stack_overflow, output ready);
endinterface

// ===== hdl/uabs_cfg_if.sv =====
// ----------------------------------------------------------------------------
// uabs_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface uabs_cfg_if import uabs_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CFGI_W-1:0]  index;
  logic [STATE_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== hdl/uabs_stack_ram.sv =====
// ----------------------------------------------------------------------------
// uabs_stack_ram
// Digit stack storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module uabs_stack_ram import uabs_pkg::*; (
  input  logic               clk,
  input  logic               we,
  input  logic [AW-1:0]      waddr,
  input  logic [DIGIT_W-1:0] wdata,
  input  logic               re,
  input  logic [AW-1:0]      raddr,
  output logic [DIGIT_W-1:0] rdata
);

  logic [DIGIT_W-1:0] mem [STACK_DEPTH];
  logic [DIGIT_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/uabs_divider.sv =====
// ----------------------------------------------------------------------------
// uabs_divider
// Restoring divider, one quotient bit per cycle, with a short mode.
// ----------------------------------------------------------------------------
module uabs_divider import uabs_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int PAD_W = DIV_W - STATE_W;

  logic              busy_r;
  logic              done_r;
  logic [DCNT_W-1:0] cnt_r;
  logic [DIV_W-1:0]  dvd_r;
  logic [REM_W-1:0]  rem_r;
  logic [PROB_W-1:0] dvs_r;

  logic [REM_W-1:0]  trial;
  logic              qbit;

  assign trial = {rem_r[REM_W-2:0], dvd_r[DIV_W-1]};
  assign qbit  = (trial >= {1'b0, dvs_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= req.short_op ? DCNT_W'(STATE_W) : DCNT_W'(DIV_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == DCNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      // Short mode places the state bits at the top; the zero padding ends up
      // above the quotient once all state bits are shifted through.
      dvd_r <= req.short_op ? {req.dividend[STATE_W-1:0], {PAD_W{1'b0}}} : req.dividend;
      rem_r <= '0;
      dvs_r <= req.divisor;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[DIV_W-2:0], qbit};
      rem_r <= qbit ? (trial - {1'b0, dvs_r}) : trial;
    end
  end

  assign rsp.busy      = busy_r;
  assign rsp.done      = done_r;
  assign rsp.quotient  = dvd_r;
  assign rsp.remainder = rem_r[PROB_W-1:0];

endmodule

// ===== hdl/uabs_binary_coder.sv =====
// Flow: restart, bad probability and unused commands go straight to the result.
// Encode pushes digits, each split off by a 24-step division by the base,
// and ends with the 42-step division of the state transform.
// Decode runs two 42-step divisions, then pops digits from the stack to
// refill the state. One item is in work at a time.
// Reset: state loads 4096, the stack is empty, and no clearing pass is needed.
// ----------------------------------------------------------------------------
// uabs_binary_coder
// Binary uABS entropy coder with a shared last-in first-out digit stack.
// ----------------------------------------------------------------------------
module uabs_binary_coder import uabs_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  uabs_in_if.sink     in_if,
  uabs_out_if.source  out_if,
  uabs_cfg_if.sink    cfg_if
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_ENC_CHK,
    S_ENC_DIG,
    S_ENC_XF,
    S_ENC_XW,
    S_DEC_MUL,
    S_DEC_Q0,
    S_DEC_Q0W,
    S_DEC_Q1,
    S_DEC_Q1W,
    S_REF_CHK,
    S_REF_ACC,
    S_FINISH
  } state_t;

  // Config registers: write only while the coder is idle; it is not enforced.
  logic [PROB_W-1:0]  prob_scale_r;
  logic [BASE_W-1:0]  digit_base_r;
  logic [STATE_W-1:0] initial_state_r;

  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prob_scale_r    <= SCALE_RESET;
      digit_base_r    <= BASE_RESET;
      initial_state_r <= INIT_RESET;
    end else if (cfg_if.valid) begin
      unique case (cfg_if.index)
        REG_PROB_SCALE:    prob_scale_r    <= cfg_if.data[PROB_W-1:0];
        REG_DIGIT_BASE:    digit_base_r    <= cfg_if.data[BASE_W-1:0];
        REG_INITIAL_STATE: initial_state_r <= cfg_if.data;
        default: ;
      endcase
    end
  end

  // Scale and base are saturated into their legal ranges wherever used.
  logic [PROB_W-1:0] l_eff;
  logic [BASE_W-1:0] b_eff;

  assign l_eff = (prob_scale_r < SCALE_MIN) ? SCALE_MIN :
                 (prob_scale_r > SCALE_MAX) ? SCALE_MAX : prob_scale_r;
  assign b_eff = (digit_base_r < BASE_MIN) ? BASE_MIN :
                 (digit_base_r > BASE_MAX) ? BASE_MAX : digit_base_r;

  // Working registers.
  state_t              state_r;
  logic [STATE_W-1:0]  x_r;
  logic [CNT_W-1:0]    cnt_r;
  logic                sym_r;
  logic [PROB_W-1:0]   p_r;
  logic [PROB_W-1:0]   share_r;
  logic [LIMIT_W-1:0]  limit_r;
  logic [DIV_W-1:0]    prod_r;
  logic [STATE_W-1:0]  q_r;
  logic                bit_r;
  logic                perr_r;
  logic                ovf_r;

  logic                out_valid_r;
  logic                out_bit_r;
  logic [STORED_W-1:0] out_stored_r;
  logic [STATE_W-1:0]  out_value_r;
  logic                out_perr_r;
  logic                out_ovf_r;

  logic                in_acc;
  logic                p_bad;
  logic [PROB_W-1:0]   in_share;
  logic                stack_full;
  logic                dec_bit;

  div_req_t            div_req;
  div_rsp_t            div_rsp;

  logic                mem_we;
  logic                mem_re;
  logic [AW-1:0]       mem_raddr;
  logic [DIGIT_W-1:0]  mem_rdata;

  assign in_if.ready = (state_r == S_IDLE);
  assign in_acc      = in_if.valid && in_if.ready;
  assign p_bad       = (in_if.prob_one == '0) || (in_if.prob_one > (l_eff - 1'b1));
  assign in_share    = in_if.symbol ? in_if.prob_one : (l_eff - in_if.prob_one);
  assign stack_full  = (cnt_r >= CNT_W'(STACK_DEPTH));
  assign dec_bit     = (div_rsp.quotient[STATE_W-1:0] != q_r);

  // Divider requests: a digit split in the encode check, the state transform,
  // and the two ceiling divisions of the decoder.
  always_comb begin
    div_req = '0;
    unique case (state_r)
      S_ENC_CHK: begin
        div_req.start    = ({{(LIMIT_W-STATE_W){1'b0}}, x_r} >= limit_r);
        div_req.short_op = 1'b1;
        div_req.dividend = DIV_W'(x_r);
        div_req.divisor  = PROB_W'(b_eff);
      end
      S_ENC_XF: begin
        div_req.start    = 1'b1;
        div_req.dividend = prod_r;
        div_req.divisor  = share_r;
      end
      S_DEC_Q0: begin
        div_req.start    = 1'b1;
        div_req.dividend = prod_r + DIV_W'(l_eff) - DIV_W'(1);
        div_req.divisor  = l_eff;
      end
      S_DEC_Q1: begin
        div_req.start    = 1'b1;
        div_req.dividend = prod_r + DIV_W'(p_r) + DIV_W'(l_eff) - DIV_W'(1);
        div_req.divisor  = l_eff;
      end
      default: ;
    endcase
  end

  uabs_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // A pushed digit goes to the top of the stack; a pop reads the entry below
  // the count. Pushes and pops never overlap, so no forwarding is needed.
  assign mem_we    = (state_r == S_ENC_DIG) && div_rsp.done && !stack_full;
  assign mem_re    = (state_r == S_REF_CHK) && (x_r < l_eff) && (cnt_r != '0);
  assign mem_raddr = AW'(cnt_r - 1'b1);

  uabs_stack_ram u_stack (
    .clk   (clk),
    .we    (mem_we),
    .waddr (cnt_r[AW-1:0]),
    .wdata (div_rsp.remainder[DIGIT_W-1:0]),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      x_r         <= INIT_RESET;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // The result register loads when it is free or being emptied, and
      // otherwise clears once the receiver takes its item.
      if (state_r == S_FINISH && (!out_valid_r || out_if.ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            sym_r   <= in_if.symbol;
            p_r     <= in_if.prob_one;
            share_r <= in_share;
            limit_r <= LIMIT_W'(b_eff) * LIMIT_W'(in_share);
            bit_r   <= 1'b0;
            perr_r  <= 1'b0;
            ovf_r   <= 1'b0;
            if (in_if.command == CMD_RESTART) begin
              x_r     <= initial_state_r;
              cnt_r   <= '0;
              state_r <= S_FINISH;
            end else if (in_if.command == CMD_ENCODE || in_if.command == CMD_DECODE) begin
              if (p_bad) begin
                perr_r  <= 1'b1;
                state_r <= S_FINISH;
              end else if (in_if.command == CMD_ENCODE) begin
                state_r <= S_ENC_CHK;
              end else begin
                state_r <= S_DEC_MUL;
              end
            end else begin
              state_r <= S_FINISH;
            end
          end
        end
        S_ENC_CHK: begin
          if (div_req.start) begin
            state_r <= S_ENC_DIG;
          end else begin
            prod_r  <= sym_r ? DIV_W'(x_r) * DIV_W'(l_eff)
                             : (DIV_W'(x_r) + DIV_W'(1)) * DIV_W'(l_eff) - DIV_W'(1);
            state_r <= S_ENC_XF;
          end
        end
        S_ENC_DIG: begin
          if (div_rsp.done) begin
            x_r <= div_rsp.quotient[STATE_W-1:0];
            if (stack_full) begin
              ovf_r <= 1'b1;
            end else begin
              cnt_r <= cnt_r + 1'b1;
            end
            state_r <= S_ENC_CHK;
          end
        end
        S_ENC_XF:  state_r <= S_ENC_XW;
        S_ENC_XW: begin
          if (div_rsp.done) begin
            x_r     <= div_rsp.quotient[STATE_W-1:0];
            state_r <= S_FINISH;
          end
        end
        S_DEC_MUL: begin
          prod_r  <= DIV_W'(x_r) * DIV_W'(p_r);
          state_r <= S_DEC_Q0;
        end
        S_DEC_Q0:  state_r <= S_DEC_Q0W;
        S_DEC_Q0W: begin
          if (div_rsp.done) begin
            q_r     <= div_rsp.quotient[STATE_W-1:0];
            state_r <= S_DEC_Q1;
          end
        end
        S_DEC_Q1:  state_r <= S_DEC_Q1W;
        S_DEC_Q1W: begin
          if (div_rsp.done) begin
            bit_r   <= dec_bit;
            x_r     <= dec_bit ? q_r : (x_r - q_r);
            state_r <= S_REF_CHK;
          end
        end
        S_REF_CHK: begin
          if (mem_re) begin
            cnt_r   <= cnt_r - 1'b1;
            state_r <= S_REF_ACC;
          end else begin
            state_r <= S_FINISH;
          end
        end
        S_REF_ACC: begin
          // The state is below the scale here, so the product fits the state.
          x_r     <= STATE_W'(PROB_W'(x_r) * STATE_W'(b_eff)) + STATE_W'(mem_rdata);
          state_r <= S_REF_CHK;
        end
        S_FINISH: begin
          if (!out_valid_r || out_if.ready) begin
            out_bit_r    <= bit_r;
            out_stored_r <= STORED_W'(cnt_r);
            out_value_r  <= x_r;
            out_perr_r   <= perr_r;
            out_ovf_r    <= ovf_r;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_if.valid          = out_valid_r;
  assign out_if.decoded_bit    = out_bit_r;
  assign out_if.digits_stored  = out_stored_r;
  assign out_if.coder_value    = out_value_r;
  assign out_if.prob_error     = out_perr_r;
  assign out_if.stack_overflow = out_ovf_r;

  // The stack count never passes the stack depth.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(STACK_DEPTH))
    else $error("stack count above depth");

  // A push only happens below the top of the stack, and raises the count.
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |=> cnt_r == $past(cnt_r) + 1'b1)
    else $error("push did not advance count");

  // A pop is only issued on a non-empty stack and lowers the count.
  a_pop_room: assert property (@(posedge clk) disable iff (!rst_n)
    mem_re |-> cnt_r != '0 ##1 cnt_r == $past(cnt_r) - 1'b1)
    else $error("pop on empty stack");

  // The divider is never restarted while it is still working.
  a_div_free: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

endmodule
